// ===== design/arma_vibration_filter_defines.svh =====
// Assertion macros used by the checker file avf_checker.sv.
`ifndef ARMA_VIBRATION_FILTER_DEFINES_SVH
`define ARMA_VIBRATION_FILTER_DEFINES_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define AVF_ASSERT_CR(label, clk_sig, rstn_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Short form on the block's own clk / rst_n.
`define AVF_ASSERT(label, prop, msg) \
  `AVF_ASSERT_CR(label, clk, rst_n, prop, msg)

`endif

// ===== design/avf_pkg.sv =====
`default_nettype none

package avf_pkg;

  localparam int DATA_W   = 24;
  localparam int ORDER_W  = 5;
  localparam int OP_W     = 2;
  localparam int INDEX_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam int AR_TAPS_DEF = 16;
  localparam int MA_TAPS_DEF = 16;

  // input op codes
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_AR = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_MA = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AR_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MA_ORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MA,
    ST_MA_DRAIN,
    ST_T16,
    ST_AR,
    ST_GAIN,
    ST_GAIN_DRAIN,
    ST_FIN
  } state_t;

  // what the accumulator does with the registered product
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_ADD,
    ACC_SUB,
    ACC_ADD_X16
  } acc_op_t;

  typedef enum logic [1:0] {
    MUL_MA,
    MUL_AR,
    MUL_GAIN
  } mul_sel_t;

endpackage

`default_nettype wire

// ===== design/arma_vibration_filter.sv =====
// Channel | Dir | Handshake           | Payload
// --------+-----+---------------------+----------------------------------
// in      | in  | in_valid / in_stall | in_op, in_index, in_value
// out     | out | out_valid/out_stall | out_vibration
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A sample walks ST_MA, ST_MA_DRAIN, ST_T16, ST_AR, ST_GAIN, ST_GAIN_DRAIN
// and ST_FIN from transfer to result, and returns to ST_IDLE before the next
// transfer; one shared multiplier and accumulator walk the taps one a cycle.
// Coefficient loads and unknown ops complete in their transfer cycle.
// Reset (rst_n low, synchronous) zeroes state, config, coefficients and histories.
// A stalled result holds in the output register; the next item is taken
// while it waits, and a later sample only parks in ST_FIN until it drains.
`default_nettype none

module arma_vibration_filter #(
  parameter int AR_TAPS = avf_pkg::AR_TAPS_DEF,  // 1..16, in_index reaches taps 0..15
  parameter int MA_TAPS = avf_pkg::MA_TAPS_DEF   // 1..16, in_index reaches taps 0..15
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // sample / load channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [avf_pkg::OP_W-1:0]             in_op,
  input  wire logic [avf_pkg::INDEX_W-1:0]          in_index,
  input  wire logic signed [avf_pkg::DATA_W-1:0]    in_value,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [avf_pkg::DATA_W-1:0]         out_vibration,
  // config write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [avf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [avf_pkg::DATA_W-1:0]           cfg_data
);

  import avf_pkg::*;

  // Widths. Tap products are Q4.20 x Q8.16 = 48 bits; the MA sum carries
  // the excitation scaled by 2^20 plus up to MAX_TAPS products.
  localparam int MAX_TAPS = (AR_TAPS > MA_TAPS) ? AR_TAPS : MA_TAPS;
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int CMP_W    = (CNT_W > ORDER_W) ? CNT_W : ORDER_W;
  localparam int MAC_W    = 2 * DATA_W + CNT_W + 2;
  localparam int T16_W    = MAC_W - 20;            // rounded MA term
  localparam int PROD_W   = T16_W + DATA_W;        // shared multiplier output
  localparam int ACC_W    = PROD_W + 5;            // room for the x16 gain term
  localparam logic signed [ACC_W-1:0] ROUND_HALF = {{(ACC_W-20){1'b0}}, 20'h80000};

  // ------------------------------------------------------------------
  // config registers
  logic [ORDER_W-1:0]       ar_order_r;
  logic [ORDER_W-1:0]       ma_order_r;
  logic signed [DATA_W-1:0] gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ar_order_r <= '0;
      ma_order_r <= '0;
      gain_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_AR_ORDER: ar_order_r <= cfg_data[ORDER_W-1:0];
        CFG_MA_ORDER: ma_order_r <= cfg_data[ORDER_W-1:0];
        CFG_GAIN:     gain_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // sequencer
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] val_r;

  logic     accept;
  logic     start;        // sample transfer
  logic     load_ar, load_ma;
  logic     rot_ma, rot_ar;
  logic     keep_tap;     // current tap lies below the active order
  logic     acc_clr;
  logic     finish;
  mul_sel_t mul_sel;
  acc_op_t  prod_op_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    start       = 1'b0;
    load_ar     = 1'b0;
    load_ma     = 1'b0;
    rot_ma      = 1'b0;
    rot_ar      = 1'b0;
    keep_tap    = 1'b0;
    acc_clr     = 1'b0;
    finish      = 1'b0;
    mul_sel     = MUL_MA;
    prod_op_nxt = ACC_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_SAMPLE: begin
              start     = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_MA;
            end
            OP_LOAD_AR: load_ar = 1'b1;
            OP_LOAD_MA: load_ma = 1'b1;
            default: ;   // op 3: dropped
          endcase
        end
      end
      ST_MA: begin
        rot_ma      = 1'b1;
        mul_sel     = MUL_MA;
        keep_tap    = CMP_W'(cnt_r) < CMP_W'(ma_order_r);
        prod_op_nxt = keep_tap ? ACC_ADD : ACC_NONE;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MA_TAPS - 1)) begin
          state_nxt = ST_MA_DRAIN;
        end
      end
      ST_MA_DRAIN: state_nxt = ST_T16;
      ST_T16: begin
        acc_clr   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_AR;
      end
      ST_AR: begin
        rot_ar      = 1'b1;
        mul_sel     = MUL_AR;
        keep_tap    = CMP_W'(cnt_r) < CMP_W'(ar_order_r);
        prod_op_nxt = keep_tap ? ACC_SUB : ACC_NONE;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(AR_TAPS - 1)) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        mul_sel     = MUL_GAIN;
        prod_op_nxt = ACC_ADD_X16;
        state_nxt   = ST_GAIN_DRAIN;
      end
      ST_GAIN_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= in_value;
    end
  end

  // ------------------------------------------------------------------
  // coefficient and history arrays; each rotates once per phase so the
  // multiplier always reads entry 0. History entries past the order rotate
  // back in as zero, which is the history clear.
  logic signed [DATA_W-1:0] ar_coef_r  [AR_TAPS];
  logic signed [DATA_W-1:0] ma_coef_r  [MA_TAPS];
  logic signed [DATA_W-1:0] out_hist_r [AR_TAPS];
  logic signed [DATA_W-1:0] exc_hist_r [MA_TAPS];
  logic signed [DATA_W-1:0] y_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AR_TAPS; k++) ar_coef_r[k] <= '0;
    end else if (load_ar) begin
      for (int k = 0; k < AR_TAPS; k++) begin
        if (32'(in_index) == k) ar_coef_r[k] <= in_value;
      end
    end else if (rot_ar) begin
      for (int k = 0; k < AR_TAPS - 1; k++) ar_coef_r[k] <= ar_coef_r[k+1];
      ar_coef_r[AR_TAPS-1] <= ar_coef_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MA_TAPS; k++) ma_coef_r[k] <= '0;
    end else if (load_ma) begin
      for (int k = 0; k < MA_TAPS; k++) begin
        if (32'(in_index) == k) ma_coef_r[k] <= in_value;
      end
    end else if (rot_ma) begin
      for (int k = 0; k < MA_TAPS - 1; k++) ma_coef_r[k] <= ma_coef_r[k+1];
      ma_coef_r[MA_TAPS-1] <= ma_coef_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AR_TAPS; k++) out_hist_r[k] <= '0;
    end else if (rot_ar) begin
      for (int k = 0; k < AR_TAPS - 1; k++) out_hist_r[k] <= out_hist_r[k+1];
      out_hist_r[AR_TAPS-1] <= keep_tap ? out_hist_r[0] : '0;
    end else if (finish) begin
      for (int k = AR_TAPS - 1; k > 0; k--) out_hist_r[k] <= out_hist_r[k-1];
      out_hist_r[0] <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MA_TAPS; k++) exc_hist_r[k] <= '0;
    end else if (rot_ma) begin
      for (int k = 0; k < MA_TAPS - 1; k++) exc_hist_r[k] <= exc_hist_r[k+1];
      exc_hist_r[MA_TAPS-1] <= keep_tap ? exc_hist_r[0] : '0;
    end else if (finish) begin
      for (int k = MA_TAPS - 1; k > 0; k--) exc_hist_r[k] <= exc_hist_r[k-1];
      exc_hist_r[0] <= val_r;
    end
  end

  // ------------------------------------------------------------------
  // shared multiplier, registered, then one accumulate a cycle
  logic signed [T16_W-1:0]  mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r;
  acc_op_t                  prod_op_r;
  logic signed [T16_W-1:0]  t16_r;

  always_comb begin
    case (mul_sel)
      MUL_AR: begin
        mul_a = {{(T16_W-DATA_W){out_hist_r[0][DATA_W-1]}}, out_hist_r[0]};
        mul_b = ar_coef_r[0];
      end
      MUL_GAIN: begin
        mul_a = t16_r;
        mul_b = gain_r;
      end
      default: begin
        mul_a = {{(T16_W-DATA_W){exc_hist_r[0][DATA_W-1]}}, exc_hist_r[0]};
        mul_b = ma_coef_r[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_op_r <= ACC_NONE;
    end else begin
      prod_op_r <= prod_op_nxt;
    end
  end

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_rnd;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    case (prod_op_r)
      ACC_ADD:     acc_nxt = acc_r + prod_ext;
      ACC_SUB:     acc_nxt = acc_r - prod_ext;
      ACC_ADD_X16: acc_nxt = acc_r + (prod_ext <<< 4);
      default:     acc_nxt = acc_r;
    endcase
    if (start) begin
      // excitation enters the MA sum at the product scale (x 2^20)
      acc_nxt = {{(ACC_W-DATA_W-20){in_value[DATA_W-1]}}, in_value, 20'd0};
    end else if (acc_clr) begin
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round half up to Q.16 (floor after adding 2^19)
  assign acc_rnd = acc_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      t16_r <= acc_rnd[T16_W+19:20];
    end
  end

  // saturate the rounded sum to 24 bits
  logic [ACC_W-44:0] y_top;
  assign y_top = acc_rnd[ACC_W-1:43];

  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y_sat = acc_rnd[43:20];
    end else if (y_top[ACC_W-44]) begin
      y_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // ------------------------------------------------------------------
  // output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_vibration_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_vibration_r <= y_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_vibration = out_vibration_r;

endmodule

`default_nettype wire

// ===== design/avf_checker.sv =====
`include "arma_vibration_filter_defines.svh"
`default_nettype none

module avf_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic [avf_pkg::OP_W-1:0]         in_op,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [avf_pkg::DATA_W-1:0]       out_vibration
);

  import avf_pkg::*;

  // a stalled result stays put
  `AVF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_vibration), "result changed under stall")

  // a sample keeps the block busy; loads finish in their transfer cycle
  `AVF_ASSERT(a_sample_busy, in_valid && !in_stall && in_op == OP_SAMPLE |=> in_stall, "not busy after sample")
  `AVF_ASSERT(a_load_quick, in_valid && !in_stall && in_op != OP_SAMPLE |=> !in_stall, "busy after load")

  // a new result only comes out of a sample in progress
  `AVF_ASSERT(a_result_src, $rose(out_valid) |-> $past(in_stall), "result without sample")

endmodule

bind arma_vibration_filter avf_checker u_avf_checker (.*);

`default_nettype wire
